/* src/swcs_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the sensor word
// checker. No dependencies.
`default_nettype none

package swcs_pkg;

    localparam int unsigned SWCS_FIFO_DEPTH = 2;

    localparam logic [7:0]  SWCS_CRC_INIT    = 8'hFF;
    localparam logic [7:0]  SWCS_CRC_POLY    = 8'h31;
    localparam logic [14:0] SWCS_TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] SWCS_TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] SWCS_TICKS_FULL  = 17'd65535;

    // Position of the next expected byte in a frame
    typedef enum logic [1:0] {
        POS_MSB = 2'd0,
        POS_LSB = 2'd1,
        POS_CRC = 2'd2
    } t_pos;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_req;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic [15:0]        raw_ticks;
        logic               crc_error;
    } t_res;

    // One checked measurement, queued between front and back
    typedef struct packed {
        logic [15:0] raw_ticks;
        logic        crc_error;
    } t_meas;

    typedef struct packed {
        logic  valid;
        t_meas meas;
    } t_push;

    // CRC-8, polynomial 0x31, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ SWCS_CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/swcs_if.sv */
// Valid/ready channel interfaces for request bytes and results.
// Depends on swcs_pkg.
`default_nettype none

interface swcs_req_if;
    logic                valid;
    logic                ready;
    swcs_pkg::t_req      payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface swcs_res_if;
    logic                valid;
    logic                ready;
    swcs_pkg::t_res      payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/swcs_front.sv */
// Front end: tracks byte position, runs the CRC and pushes one measurement
// per completed frame. Depends on swcs_pkg and swcs_if.
`default_nettype none

module swcs_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    swcs_req_if.sink        i_req,
    input  wire logic       i_full,
    output swcs_pkg::t_push o_push
);
    import swcs_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic        w_accept;
    logic        w_fresh;

    assign i_req.ready = !i_full;
    assign w_accept    = i_req.valid && i_req.ready;

    // Frame start, or any position other than LSB/CRC, takes the byte as MSB
    always_comb begin
        case (r_pos)
            POS_LSB, POS_CRC: w_fresh = i_req.payload.frame_start;
            default:          w_fresh = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_high = r_high;
        n_low  = r_low;
        if (w_accept) begin
            if (w_fresh) begin
                n_pos  = POS_LSB;
                n_crc  = crc8_byte(SWCS_CRC_INIT, i_req.payload.rx_byte);
                n_high = i_req.payload.rx_byte;
            end else begin
                case (r_pos)
                    POS_LSB: begin
                        n_pos = POS_CRC;
                        n_crc = crc8_byte(r_crc, i_req.payload.rx_byte);
                        n_low = i_req.payload.rx_byte;
                    end
                    default: begin
                        n_pos = POS_MSB;
                        n_crc = SWCS_CRC_INIT;
                    end
                endcase
            end
        end
    end

    // Outputs
    always_comb begin
        o_push.valid          = w_accept && !w_fresh && (r_pos == POS_CRC);
        o_push.meas.raw_ticks = {r_high, r_low};
        o_push.meas.crc_error = (i_req.payload.rx_byte != r_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_MSB;
            r_crc  <= SWCS_CRC_INIT;
            r_high <= 8'd0;
            r_low  <= 8'd0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

`default_nettype wire

/* src/swcs_fifo.sv */
// Short queue of checked measurements between front and back end.
// Depends on swcs_pkg.
`default_nettype none

module swcs_fifo #(
    parameter int unsigned DEPTH = swcs_pkg::SWCS_FIFO_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire swcs_pkg::t_push i_push,
    output logic            o_full,
    output logic            o_valid,
    output swcs_pkg::t_meas o_meas,
    input  wire logic       i_pop
);
    import swcs_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_meas          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_wr_en;
    logic           w_rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_meas  = r_mem[r_rd];
    assign w_wr_en = i_push.valid && !o_full;
    assign w_rd_en = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd_en && !w_wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.meas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* src/swcs_scale.sv */
// Back end: scales ticks to centidegrees in two stages and holds the result
// in the output register. Depends on swcs_pkg and swcs_if.
`default_nettype none

module swcs_scale (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire swcs_pkg::t_meas i_meas,
    output logic            o_pop,
    swcs_res_if.source      o_res
);
    import swcs_pkg::*;

    logic        r_s1_valid;
    logic [30:0] r_s1_prod;
    t_meas       r_s1_meas;
    logic        r_out_valid;
    t_res        r_out;

    logic        w_out_load;
    logic        w_s1_load;
    logic [14:0] w_hi;
    logic [15:0] w_lo;
    logic [16:0] w_sum;
    logic [14:0] w_quot;

    assign w_out_load = r_s1_valid && (!r_out_valid || o_res.ready);
    assign w_s1_load  = i_valid && (!r_s1_valid || w_out_load);
    assign o_pop      = w_s1_load;

    // p = hi*65536 + lo = hi*65535 + (hi + lo); hi + lo < 2*65535
    assign w_hi   = r_s1_prod[30:16];
    assign w_lo   = r_s1_prod[15:0];
    assign w_sum  = 17'(w_hi) + 17'(w_lo);
    assign w_quot = w_hi + ((w_sum >= SWCS_TICKS_FULL) ? 15'd1 : 15'd0);

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_prod <= 31'(i_meas.raw_ticks) * 31'(SWCS_TEMP_SPAN);
            r_s1_meas <= i_meas;
        end
        if (w_out_load) begin
            r_out.temp_centi <= signed'(w_quot - SWCS_TEMP_OFFSET);
            r_out.raw_ticks  <= r_s1_meas.raw_ticks;
            r_out.crc_error  <= r_s1_meas.crc_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

/* src/sensor_word_crc_check_and_scale.sv */
// Top level: sensor word CRC check and temperature scaling.
// Depends on swcs_pkg, swcs_if, swcs_front, swcs_fifo, swcs_scale.
//
//   channel | dir | payload                                  | request
//   i_req   | in  | rx_byte[7:0], frame_start                | one sensor byte
//   o_res   | out | temp_centi[14:0] s, raw_ticks[15:0], crc_error | one frame result
//
// One byte is accepted per cycle while the queue is not full. The CRC byte of a
// frame is written into the queue at the edge that accepts it; its result then
// passes the multiply stage and the output register on its way to o_res.
// Reset (synchronous, active low) clears byte position, CRC, queue and valids.
// A stalled output fills the output register, multiply stage and queue in
// turn; only then does i_req.ready drop.
`default_nettype none

module sensor_word_crc_check_and_scale #(
    parameter int unsigned FIFO_DEPTH = swcs_pkg::SWCS_FIFO_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swcs_req_if.sink   i_req,
    swcs_res_if.source o_res
);
    import swcs_pkg::*;

    t_push w_push;
    logic  w_full;
    logic  w_q_valid;
    t_meas w_q_meas;
    logic  w_pop;

    swcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    swcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_meas  (w_q_meas),
        .i_pop   (w_pop)
    );

    swcs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_meas  (w_q_meas),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for sensor_word_crc_check_and_scale: byte frames with
// good and bad CRCs, resyncs, random gaps and back-pressure, checked against a local model.
// Depends on swcs_pkg, swcs_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import swcs_pkg::*;

    localparam int RANDOM_BYTES   = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_PERCENT   = 24;
    localparam int LONG_HOLD      = 150;

    logic i_clk;
    logic i_rst_n;

    swcs_req_if req_if ();
    swcs_res_if res_if ();

    sensor_word_crc_check_and_scale DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    // Local model of the frame parser
    t_pos       frame_pos;
    logic [7:0] frame_crc;
    logic [7:0] frame_msb;
    logic [7:0] frame_lsb;

    t_res expected_readings[$];

    int  bytes_sent;
    int  readings_checked;
    int  crc_flags_seen;
    int  bad_readings;
    int  stray_readings;
    int  hold_cycles;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Timeout: %0d readings still outstanding", expected_readings.size());
        $display("== FAIL ==");
        $finish;
    end

    // CRC-8, poly 0x31, MSB first, one bit per step
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? SWCS_CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] ticks);
        return crc8_update(crc8_update(SWCS_CRC_INIT, ticks[15:8]), ticks[7:0]);
    endfunction

    // Advance the frame model by one accepted request
    task automatic track_byte(input logic [7:0] b, input logic start);
        t_res       r;
        int         scaled;
        logic [15:0] ticks;
        if (start || frame_pos == POS_MSB) begin
            frame_msb = b;
            frame_crc = crc8_update(SWCS_CRC_INIT, b);
            frame_pos = POS_LSB;
        end else if (frame_pos == POS_LSB) begin
            frame_lsb = b;
            frame_crc = crc8_update(frame_crc, b);
            frame_pos = POS_CRC;
        end else begin
            ticks        = {frame_msb, frame_lsb};
            scaled       = (17500 * int'(ticks)) / 65535;
            r.temp_centi = 15'(scaled - 4500);
            r.raw_ticks  = ticks;
            r.crc_error  = (b != frame_crc);
            expected_readings.push_back(r);
            frame_pos = POS_MSB;
            frame_crc = SWCS_CRC_INIT;
        end
    endtask

    task automatic report_mismatch(input t_res exp_r, input t_res got_r);
        bad_readings++;
        if (bad_readings <= MAX_REPORTS) begin
            $display("Mismatch at %0t: expected temp=%0d ticks=%h crc_err=%b, got temp=%0d ticks=%h crc_err=%b",
                     $time, exp_r.temp_centi, exp_r.raw_ticks, exp_r.crc_error,
                     got_r.temp_centi, got_r.raw_ticks, got_r.crc_error);
        end
    endtask

    // Result checker and request monitor
    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_r = res_if.payload;
            if (expected_readings.size() == 0) begin
                stray_readings++;
                if (stray_readings + bad_readings <= MAX_REPORTS) begin
                    $display("Unexpected reading at %0t: temp=%0d ticks=%h crc_err=%b",
                             $time, got_r.temp_centi, got_r.raw_ticks, got_r.crc_error);
                end
            end else begin
                exp_r = expected_readings.pop_front();
                readings_checked++;
                if (got_r.crc_error) crc_flags_seen++;
                if (got_r.temp_centi !== exp_r.temp_centi ||
                    got_r.raw_ticks  !== exp_r.raw_ticks ||
                    got_r.crc_error  !== exp_r.crc_error) begin
                    report_mismatch(exp_r, got_r);
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            track_byte(req_if.payload.rx_byte, req_if.payload.frame_start);
        end
    end

    // Receiver: random stalls plus a counted long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                res_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        t_req rq;
        rq.rx_byte     = b;
        rq.frame_start = start;
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= rq;
        do @(posedge i_clk); while (!req_if.ready);
        bytes_sent++;
    endtask

    task automatic release_req();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [15:0] ticks, input bit crc_ok, input logic start);
        logic [7:0] c;
        c = word_crc(ticks);
        if (!crc_ok) c = c ^ 8'($urandom_range(1, 255));
        send_byte(ticks[15:8], start);
        send_byte(ticks[7:0], 1'b0);
        send_byte(c, 1'b0);
    endtask

    // Sender pause: wait until every pending reading has been checked
    task automatic drain_readings();
        release_req();
        wait (expected_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_scale_extremes();
        idle_on = 1'b1;
        send_frame(16'h0000, 1'b1, 1'b1);
        send_frame(16'hFFFF, 1'b1, 1'b1);
        send_frame(16'h8000, 1'b1, 1'b0);
        send_frame(16'h0001, 1'b1, 1'b0);
        send_frame(16'hFFFE, 1'b0, 1'b1);
        send_frame(16'h5A3C, 1'b0, 1'b0);
        drain_readings();
    endtask

    task automatic test_frame_resync();
        // frame start on the LSB slot: partial frame dropped
        send_byte(8'h12, 1'b1);
        send_frame(16'hBEEF, 1'b1, 1'b1);
        // frame start on the CRC slot
        send_byte(8'h34, 1'b1);
        send_byte(8'h56, 1'b0);
        send_frame(16'h6666, 1'b0, 1'b1);
        drain_readings();
    endtask

    task automatic test_back_pressure();
        idle_on = 1'b0;
        @(posedge i_clk);
        hold_cycles = LONG_HOLD;
        repeat (20) send_frame(16'($urandom), $urandom_range(0, 9) != 0, 1'b1);
        drain_readings();
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int  stop_at;
        int  kind;
        bit  need_sync;
        logic [15:0] ticks;
        stop_at   = bytes_sent + RANDOM_BYTES;
        need_sync = 1'b0;
        while (bytes_sent < stop_at) begin
            // quiet stretch in the middle with no gaps on either side
            idle_on = !((stop_at - bytes_sent) inside {[400:650]});
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                ticks = ($urandom_range(0, 9) == 0) ?
                        (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
                send_frame(ticks, $urandom_range(0, 6) != 0,
                           need_sync || $urandom_range(0, 1) == 1);
                need_sync = 1'b0;
            end else if (kind < 92) begin
                // truncated frame, next one resyncs
                send_byte(8'($urandom), 1'b1);
                if ($urandom_range(0, 1) == 1) send_byte(8'($urandom), 1'b0);
                need_sync = 1'b1;
            end else begin
                send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                need_sync = 1'b1;
            end
        end
        drain_readings();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        frame_pos      = POS_MSB;
        frame_crc      = SWCS_CRC_INIT;
        frame_msb      = '0;
        frame_lsb      = '0;
        hold_cycles    = 0;
        idle_on        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_scale_extremes();
        test_frame_resync();
        test_back_pressure();
        test_random_frames();

        $display("Sent %0d sensor bytes, checked %0d readings (%0d with CRC error flagged).",
                 bytes_sent, readings_checked, crc_flags_seen);
        $display("Covered scale extremes, resync on every slot, long output stall, random gaps.");
        if (bad_readings == 0 && stray_readings == 0 && expected_readings.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Mismatches: %0d, unexpected: %0d, missing: %0d",
                     bad_readings, stray_readings, expected_readings.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
